/* hdl/mtf_pkg.sv */
`timescale 1ns / 1ps

package mtf_pkg;

  localparam int SYM_W             = 8;
  localparam int DEF_ALPHABET_SIZE = 256;

  localparam logic [SYM_W-1:0] NO_MATCH_CODE = 8'hFF;

  localparam logic DIR_ENCODE = 1'b0;
  localparam logic DIR_DECODE = 1'b1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_HOLD
  } state_t;

  // Token moving down the cell chain. Before the hit, carry holds the entry
  // shifted out of the previous cell; after the hit it holds the found symbol.
  typedef struct packed {
    logic             valid;
    logic             found;
    logic [SYM_W-1:0] carry;
    logic [SYM_W-1:0] rank;
  } token_t;

endpackage

/* hdl/mtf_if.sv */
`timescale 1ns / 1ps

interface mtf_in_if;
  import mtf_pkg::*;
  logic             valid;
  logic             ready;
  logic [SYM_W-1:0] symbol_in;
  logic             end_of_buffer;
  modport source (output valid, output symbol_in, output end_of_buffer, input ready);
  modport sink   (input valid, input symbol_in, input end_of_buffer, output ready);
endinterface

interface mtf_out_if;
  import mtf_pkg::*;
  logic             valid;
  logic             ready;
  logic [SYM_W-1:0] symbol_out;
  logic             last;
  modport source (output valid, output symbol_out, output last, input ready);
  modport sink   (input valid, input symbol_out, input last, output ready);
endinterface

interface mtf_cfg_if;
  logic valid;
  logic ready;
  logic data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* hdl/mtf_cell.sv */
`timescale 1ns / 1ps

module mtf_cell #(
  parameter int INDEX = 0
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      mode,
  input  logic [mtf_pkg::SYM_W-1:0] key,
  input  logic                      load,
  input  logic [mtf_pkg::SYM_W-1:0] load_value,
  input  mtf_pkg::token_t           tok_in,
  output mtf_pkg::token_t           tok_out,
  output logic [mtf_pkg::SYM_W-1:0] entry
);
  import mtf_pkg::*;

  localparam logic [SYM_W-1:0] INDEX_B = SYM_W'(INDEX);

  logic   hit;
  logic   active;
  token_t tok_next;

  assign active = tok_in.valid && !tok_in.found;

  always_comb begin
    if (mode == DIR_DECODE) begin
      hit = active && (key == INDEX_B);
    end else begin
      hit = active && (entry == key);
    end
    tok_next.valid = tok_in.valid;
    tok_next.found = tok_in.found || hit;
    tok_next.carry = tok_in.found ? tok_in.carry : entry;
    tok_next.rank  = hit ? INDEX_B : tok_in.rank;
  end

  // Up to and including the hit cell, every cell takes the entry carried in by the token.
  always_ff @(posedge clk) begin
    if (rst) begin
      entry <= INDEX_B;
    end else if (load) begin
      entry <= load_value;
    end else if (active) begin
      entry <= tok_in.carry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.valid <= 1'b0;
    end else begin
      tok_out <= tok_next;
    end
  end

endmodule

/* hdl/move_to_front_byte_transform.sv */
`timescale 1ns / 1ps

// Move-to-front transform over a recency list of ALPHABET_SIZE bytes.
// din  : item in (symbol_in, end_of_buffer), valid/ready.
// dout : item out (symbol_out, last), valid/ready, driven from a register.
// cfg  : one-bit direction write (0 encode byte to rank, 1 decode rank to
//        byte); write only while no item is in flight.
// The list sits in a row of ALPHABET_SIZE cells, one entry each. An accepted
// item launches a token that steps one cell per clock from the head; cells
// up to the hit shift down, the token captures the hit cell's symbol and
// rank, and the head is rewritten when the token leaves the tail.
// The result is registered when the token leaves the tail, then moved to
// the output register; a new item is taken once the previous result has
// moved there, so the block does not take a new item while one is in the
// chain. An encode byte outside a smaller alphabet skips the chain and
// returns 255 via the hold state and the output register.
// Reset (rst, synchronous) loads identity order (cell k holds k), selects
// encode and empties the output. A stalled dout holds its item; the result
// of a following item waits inside until the output frees, holding off din.
module move_to_front_byte_transform #(
  parameter int ALPHABET_SIZE = mtf_pkg::DEF_ALPHABET_SIZE
) (
  input  logic       clk,
  input  logic       rst,
  mtf_in_if.sink     din,
  mtf_out_if.source  dout,
  mtf_cfg_if.sink    cfg
);
  import mtf_pkg::*;

  localparam logic [SYM_W:0]   ALPHA_EXT = (SYM_W + 1)'(ALPHABET_SIZE);
  localparam logic [SYM_W-1:0] LAST_POS  = SYM_W'(ALPHABET_SIZE - 1);

  state_t           state, state_next;
  logic             direction;
  logic [SYM_W-1:0] key;
  logic             eob;
  logic [SYM_W-1:0] pend;
  logic             inj_valid;
  logic             out_valid;
  logic [SYM_W-1:0] out_sym;
  logic             out_last;
  logic             take;
  logic             walk_start;
  logic             out_free;
  logic             out_range;
  logic             head_load;

  token_t           tok   [ALPHABET_SIZE+1];
  logic [SYM_W-1:0] entry [ALPHABET_SIZE];

  assign cfg.ready       = 1'b1;
  assign dout.valid      = out_valid;
  assign dout.symbol_out = out_sym;
  assign dout.last       = out_last;

  assign out_free  = !out_valid || dout.ready;
  assign out_range = ({1'b0, din.symbol_in} >= ALPHA_EXT);
  assign head_load = (state == S_WALK) && tok[ALPHABET_SIZE].valid;

  always_comb begin
    state_next = state;
    din.ready  = (state == S_IDLE);
    take       = din.valid && (state == S_IDLE);
    walk_start = 1'b0;
    case (state)
      S_IDLE: begin
        if (take) begin
          if (direction == DIR_ENCODE && out_range) begin
            state_next = S_HOLD;
          end else begin
            walk_start = 1'b1;
            state_next = S_WALK;
          end
        end
      end
      S_WALK: begin
        if (tok[ALPHABET_SIZE].valid) begin
          state_next = S_HOLD;
        end
      end
      S_HOLD: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      direction <= DIR_ENCODE;
      inj_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      inj_valid <= walk_start;
      if (cfg.valid && cfg.ready) begin
        direction <= cfg.data;
      end
      if (take) begin
        key  <= out_range ? LAST_POS : din.symbol_in;
        eob  <= din.end_of_buffer;
        pend <= NO_MATCH_CODE;
      end
      if (head_load) begin
        pend <= (direction == DIR_DECODE) ? tok[ALPHABET_SIZE].carry
                                          : tok[ALPHABET_SIZE].rank;
      end
      if (state == S_HOLD && out_free) begin
        out_valid <= 1'b1;
        out_sym   <= pend;
        out_last  <= eob;
      end else if (dout.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Head token carries the head's own entry, so cell 0 keeps it on a miss.
  always_comb begin
    tok[0].valid = inj_valid;
    tok[0].found = 1'b0;
    tok[0].carry = entry[0];
    tok[0].rank  = '0;
  end

  for (genvar i = 0; i < ALPHABET_SIZE; i++) begin : g_cell
    mtf_cell #(
      .INDEX(i)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .mode       (direction),
      .key        (key),
      .load       (head_load && (i == 0)),
      .load_value (tok[ALPHABET_SIZE].carry),
      .tok_in     (tok[i]),
      .tok_out    (tok[i+1]),
      .entry      (entry[i])
    );
  end

  // Every in-range key is in the list, so a token always leaves found.
  a_tail_found: assert property (@(posedge clk) disable iff (rst)
    tok[ALPHABET_SIZE].valid |-> tok[ALPHABET_SIZE].found)
    else $error("token left the chain without a hit");

  a_tail_in_walk: assert property (@(posedge clk) disable iff (rst)
    tok[ALPHABET_SIZE].valid |-> state == S_WALK)
    else $error("token at tail outside a walk");

  a_inject_once: assert property (@(posedge clk) disable iff (rst)
    inj_valid |-> $past(state) == S_IDLE && state == S_WALK)
    else $error("token launched outside item start");

  a_hold_release: assert property (@(posedge clk) disable iff (rst)
    state == S_HOLD && out_free |=> out_valid && state == S_IDLE)
    else $error("held result not moved to output");

endmodule
